// ===== rtl/core/pecs_pkg.sv =====
// ----------------------------------------------------------------------------
// pecs_pkg
// Shared types for the polygon edge clip stage: controller states, datapath
// command and status groups, and register indexes.
// ----------------------------------------------------------------------------
package pecs_pkg;

   // Controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EF_M1,
      ST_EF_M1W,
      ST_EF_M2,
      ST_EF_M2W,
      ST_EF_STORE,
      ST_SET_EDGE,
      ST_CLIP,
      ST_INT_CHECK,
      ST_NUM_M1,
      ST_NUM_M1W,
      ST_NUM_M2,
      ST_NUM_M2W,
      ST_DIV,
      ST_DIVW,
      ST_PUSH_A,
      ST_PUSH_Q,
      ST_PUSH_B,
      ST_EDGE_DONE,
      ST_CHECK_LAST,
      ST_FLUSH
   } state_type;

   // Point whose edge function is evaluated
   typedef enum logic [1:0] {
      PT_CUR,
      PT_FIRST,
      PT_A,
      PT_B
   } point_type;

   // Multiplier operation: first product loads the accumulator, second subtracts
   typedef enum logic [1:0] {
      MUL_EF1,
      MUL_EF2,
      MUL_N1,
      MUL_N2
   } mul_op_type;

   // Source of a pushed vertex
   typedef enum logic [1:0] {
      SRC_A,
      SRC_B,
      SRC_Q
   } push_src_type;

   typedef enum logic {
      EDGE_PREV_CUR,
      EDGE_CUR_FIRST
   } edge_sel_type;

   typedef enum logic {
      COORD_X,
      COORD_Y
   } coord_type;

   // Register indexes of the configuration port
   localparam logic [1:0] REG_START_X = 2'd0;
   localparam logic [1:0] REG_START_Y = 2'd1;
   localparam logic [1:0] REG_END_X   = 2'd2;
   localparam logic [1:0] REG_END_Y   = 2'd3;

   typedef struct packed {
      logic         load;
      logic         mul_start;
      mul_op_type   mul_op;
      point_type    point;
      logic         store_e;
      logic         set_edge;
      edge_sel_type edge_sel;
      logic         div_start;
      coord_type    coord;
      logic         push;
      push_src_type push_src;
      logic         flush;
      logic         commit;
   } cmd_type;

   typedef struct packed {
      logic have_first;
      logic last;
      logic a_in;
      logic b_in;
      logic den_zero;
      logic mul_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/pecs_mul.sv =====
// ----------------------------------------------------------------------------
// pecs_mul
// Serial signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pecs_mul #(
   parameter int WA = 35,
   parameter int WB = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [WA-1:0]  a,
   input  logic signed [WB-1:0]  b,
   output logic                  done,
   output logic signed [WA+WB-1:0] prod
);
   localparam int WP = WA + WB;
   localparam int CW = $clog2(WB + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [WP-1:0] mcand_ff, mcand_in;
   logic [WB-1:0]        mplier_ff, mplier_in;
   logic signed [WP-1:0] acc_ff, acc_in;
   logic signed [WP-1:0] term;
   logic                 at_sign;

   // Add one partial product; the sign bit of b weighs negative
   always_comb begin
      term      = mplier_ff[0] ? mcand_ff : '0;
      at_sign   = (cnt_ff == CW'(WB - 1));
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = WP'(a);
         mplier_in = b;
         acc_in    = '0;
      end else if (busy_ff) begin
         acc_in    = at_sign ? (acc_ff - term) : (acc_ff + term);
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + CW'(1);
         if (at_sign) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== rtl/core/pecs_div.sv =====
// ----------------------------------------------------------------------------
// pecs_div
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero, with the quotient saturated to QW bits.
// ----------------------------------------------------------------------------
module pecs_div #(
   parameter int NW = 52,
   parameter int DW = 36,
   parameter int QW = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic                 done,
   output logic signed [QW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   localparam logic [NW-1:0] POS_LIM = {{(NW-QW+1){1'b0}}, {(QW-1){1'b1}}};
   localparam logic [NW-1:0] NEG_LIM = POS_LIM + NW'(1);

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [NW-1:0]        q_ff, q_in;
   logic [DW-1:0]        d_ff, d_in;
   logic [DW-1:0]        r_ff, r_in;
   logic                 neg_ff, neg_in;
   logic signed [QW-1:0] quo_ff, quo_in;
   logic [DW:0]          r_sh;
   logic                 fits;
   logic [NW-1:0]        q_sat;
   logic [NW-1:0]        q_res;

   always_comb begin
      r_sh    = {r_ff, n_ff[NW-1]};
      fits    = (r_sh >= {1'b0, d_ff});
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      q_sat   = '0;
      q_res   = '0;
      if (start) begin
         // Take magnitudes and remember the sign of the quotient
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = num[NW-1] ? NW'(-num) : NW'(num);
         d_in    = den[DW-1] ? DW'(-den) : DW'(den);
         neg_in  = num[NW-1] ^ den[DW-1];
         r_in    = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         // One restoring step
         r_in   = fits ? DW'(r_sh - {1'b0, d_ff}) : r_sh[DW-1:0];
         q_in   = {q_ff[NW-2:0], fits};
         n_in   = n_ff << 1;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // Saturate and apply the sign
         if (neg_ff) begin
            q_sat = (q_ff > NEG_LIM) ? NEG_LIM : q_ff;
            q_res = -q_sat;
         end else begin
            q_sat = (q_ff > POS_LIM) ? POS_LIM : q_ff;
            q_res = q_sat;
         end
         quo_in  = q_res[QW-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/core/pecs_dpath.sv =====
// ----------------------------------------------------------------------------
// pecs_dpath
// Datapath of the clip stage: vertex state, edge functions, intercept
// numerators, shared multiplier and divider, and the result registers.
// ----------------------------------------------------------------------------
module pecs_dpath #(
   parameter int C = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  pecs_pkg::cmd_type   cmd,
   output pecs_pkg::status_type sts,
   input  logic signed [C-1:0] in_x,
   input  logic signed [C-1:0] in_y,
   input  logic                in_last,
   input  logic signed [C-1:0] start_x,
   input  logic signed [C-1:0] start_y,
   input  logic signed [C-1:0] end_x,
   input  logic signed [C-1:0] end_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [C-1:0] rsp_x,
   output logic signed [C-1:0] rsp_y,
   output logic                rsp_vv,
   output logic                rsp_pe
);
   localparam int DWID = C + 1;
   localparam int EW   = 2 * C + 3;
   localparam int NW   = 3 * C + 4;
   localparam int DENW = 2 * C + 4;

   logic signed [C-1:0]    cur_x_ff, cur_y_ff, first_x_ff, first_y_ff;
   logic signed [C-1:0]    prev_x_ff, prev_y_ff;
   logic signed [C-1:0]    ax_ff, ay_ff, bx_ff, by_ff, qx_ff, qy_ff;
   logic signed [C-1:0]    pend_x_ff, pend_y_ff, rsp_x_ff, rsp_y_ff;
   logic                   last_ff, prev_in_ff, have_first_ff, cin_ff, fin_ff;
   logic                   ain_ff, bin_ff, pend_valid_ff, rsp_valid_ff;
   logic                   rsp_vv_ff, rsp_pe_ff;
   logic signed [EW-1:0]   ea_ff, eb_ff;
   logic signed [NW-1:0]   acc_ff;
   pecs_pkg::mul_op_type   mul_op_ff;

   logic signed [DWID-1:0] dx, dy, px, py;
   logic signed [C-1:0]    pt_x, pt_y, push_x, push_y;
   logic signed [EW-1:0]   mul_a;
   logic signed [DWID-1:0] mul_b;
   logic signed [NW-1:0]   prod;
   logic                   mul_done, div_done;
   logic signed [C-1:0]    quo;
   logic signed [DENW-1:0] den;
   logic signed [EW-1:0]   e_val;
   logic                   e_inside, out_free;

   // Select the point for the edge function
   always_comb begin
      unique case (cmd.point)
         pecs_pkg::PT_CUR:   begin pt_x = cur_x_ff;   pt_y = cur_y_ff;   end
         pecs_pkg::PT_FIRST: begin pt_x = first_x_ff; pt_y = first_y_ff; end
         pecs_pkg::PT_A:     begin pt_x = ax_ff;      pt_y = ay_ff;      end
         pecs_pkg::PT_B:     begin pt_x = bx_ff;      pt_y = by_ff;      end
      endcase
   end

   assign dx = DWID'(end_x) - DWID'(start_x);
   assign dy = DWID'(end_y) - DWID'(start_y);
   assign px = DWID'(pt_x) - DWID'(start_x);
   assign py = DWID'(pt_y) - DWID'(start_y);

   // Multiplier operands
   always_comb begin
      unique case (cmd.mul_op)
         pecs_pkg::MUL_EF1: begin mul_a = EW'(dx); mul_b = py; end
         pecs_pkg::MUL_EF2: begin mul_a = EW'(dy); mul_b = px; end
         pecs_pkg::MUL_N1: begin
            mul_a = ea_ff;
            mul_b = (cmd.coord == pecs_pkg::COORD_Y) ? DWID'(by_ff) : DWID'(bx_ff);
         end
         pecs_pkg::MUL_N2: begin
            mul_a = eb_ff;
            mul_b = (cmd.coord == pecs_pkg::COORD_Y) ? DWID'(ay_ff) : DWID'(ax_ff);
         end
      endcase
   end

   pecs_mul #(.WA(EW), .WB(DWID)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   assign den = DENW'(ea_ff) - DENW'(eb_ff);

   pecs_div #(.NW(NW), .DW(DENW), .QW(C)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (acc_ff),
      .den   (den),
      .done  (div_done),
      .quo   (quo)
   );

   assign e_val    = acc_ff[EW-1:0];
   assign e_inside = e_val[EW-1] | (e_val == '0);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Vertex to push
   always_comb begin
      unique case (cmd.push_src)
         pecs_pkg::SRC_A: begin push_x = ax_ff; push_y = ay_ff; end
         pecs_pkg::SRC_B: begin push_x = bx_ff; push_y = by_ff; end
         pecs_pkg::SRC_Q: begin push_x = qx_ff; push_y = qy_ff; end
         default:         begin push_x = qx_ff; push_y = qy_ff; end
      endcase
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
         prev_in_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            have_first_ff <= !last_ff;
            prev_in_ff    <= cin_ff;
         end
         if (cmd.push) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         // Load from the pending slot or an empty-polygon report, else drop a transfer that was taken
         priority if (cmd.push && pend_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (cmd.flush && (pend_valid_ff || last_ff)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= in_x;
         cur_y_ff <= in_y;
         last_ff  <= in_last;
         if (!have_first_ff) begin
            first_x_ff <= in_x;
            first_y_ff <= in_y;
         end
      end
      if (cmd.commit) begin
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
      end
      if (cmd.mul_start) begin
         mul_op_ff <= cmd.mul_op;
      end
      // Accumulate products: the first of a pair loads, the second subtracts
      if (mul_done) begin
         if (mul_op_ff == pecs_pkg::MUL_EF1 || mul_op_ff == pecs_pkg::MUL_N1) begin
            acc_ff <= prod;
         end else begin
            acc_ff <= acc_ff - prod;
         end
      end
      if (cmd.store_e) begin
         unique case (cmd.point)
            pecs_pkg::PT_CUR:   cin_ff <= e_inside;
            pecs_pkg::PT_FIRST: fin_ff <= e_inside;
            pecs_pkg::PT_A:     ea_ff  <= e_val;
            pecs_pkg::PT_B:     eb_ff  <= e_val;
         endcase
      end
      if (cmd.set_edge) begin
         if (cmd.edge_sel == pecs_pkg::EDGE_PREV_CUR) begin
            ax_ff  <= prev_x_ff;
            ay_ff  <= prev_y_ff;
            ain_ff <= prev_in_ff;
            bx_ff  <= cur_x_ff;
            by_ff  <= cur_y_ff;
            bin_ff <= cin_ff;
         end else begin
            ax_ff  <= cur_x_ff;
            ay_ff  <= cur_y_ff;
            ain_ff <= cin_ff;
            bx_ff  <= first_x_ff;
            by_ff  <= first_y_ff;
            bin_ff <= fin_ff;
         end
      end
      if (div_done) begin
         if (cmd.coord == pecs_pkg::COORD_Y) begin
            qy_ff <= quo;
         end else begin
            qx_ff <= quo;
         end
      end
      if (cmd.push) begin
         pend_x_ff <= push_x;
         pend_y_ff <= push_y;
         if (pend_valid_ff) begin
            rsp_x_ff  <= pend_x_ff;
            rsp_y_ff  <= pend_y_ff;
            rsp_vv_ff <= 1'b1;
            rsp_pe_ff <= 1'b0;
         end
      end
      // Flush the pending vertex, or report an empty polygon
      if (cmd.flush) begin
         if (pend_valid_ff) begin
            rsp_x_ff  <= pend_x_ff;
            rsp_y_ff  <= pend_y_ff;
            rsp_vv_ff <= 1'b1;
            rsp_pe_ff <= last_ff;
         end else if (last_ff) begin
            rsp_x_ff  <= '0;
            rsp_y_ff  <= '0;
            rsp_vv_ff <= 1'b0;
            rsp_pe_ff <= 1'b1;
         end
      end
   end

   assign sts.have_first = have_first_ff;
   assign sts.last       = last_ff;
   assign sts.a_in       = ain_ff;
   assign sts.b_in       = bin_ff;
   assign sts.den_zero   = (den == '0);
   assign sts.mul_done   = mul_done;
   assign sts.div_done   = div_done;
   assign sts.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x     = rsp_x_ff;
   assign rsp_y     = rsp_y_ff;
   assign rsp_vv    = rsp_vv_ff;
   assign rsp_pe    = rsp_pe_ff;

endmodule

// ===== rtl/core/pecs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pecs_ctrl
// Sequencer of the clip stage: walks each vertex through its edge function
// evaluations, edge decisions, intercept arithmetic and result pushes.
// ----------------------------------------------------------------------------
module pecs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pecs_pkg::status_type sts,
   output pecs_pkg::cmd_type    cmd
);
   pecs_pkg::state_type    state_ff, state_in;
   pecs_pkg::point_type    point_ff, point_in;
   pecs_pkg::edge_sel_type edge_ff, edge_in;
   pecs_pkg::coord_type    coord_ff, coord_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      point_in = point_ff;
      edge_in  = edge_ff;
      coord_in = coord_ff;
      unique case (state_ff)
         pecs_pkg::ST_IDLE: begin
            if (req_valid) begin
               point_in = pecs_pkg::PT_CUR;
               state_in = pecs_pkg::ST_EF_M1;
            end
         end
         pecs_pkg::ST_EF_M1:  state_in = pecs_pkg::ST_EF_M1W;
         pecs_pkg::ST_EF_M1W: if (sts.mul_done) state_in = pecs_pkg::ST_EF_M2;
         pecs_pkg::ST_EF_M2:  state_in = pecs_pkg::ST_EF_M2W;
         pecs_pkg::ST_EF_M2W: if (sts.mul_done) state_in = pecs_pkg::ST_EF_STORE;
         pecs_pkg::ST_EF_STORE: begin
            unique case (point_ff)
               pecs_pkg::PT_CUR: begin
                  if (sts.have_first) begin
                     edge_in  = pecs_pkg::EDGE_PREV_CUR;
                     state_in = pecs_pkg::ST_SET_EDGE;
                  end else begin
                     state_in = pecs_pkg::ST_CHECK_LAST;
                  end
               end
               pecs_pkg::PT_FIRST: begin
                  edge_in  = pecs_pkg::EDGE_CUR_FIRST;
                  state_in = pecs_pkg::ST_SET_EDGE;
               end
               pecs_pkg::PT_A: begin
                  point_in = pecs_pkg::PT_B;
                  state_in = pecs_pkg::ST_EF_M1;
               end
               pecs_pkg::PT_B: state_in = pecs_pkg::ST_INT_CHECK;
            endcase
         end
         pecs_pkg::ST_SET_EDGE: state_in = pecs_pkg::ST_CLIP;
         pecs_pkg::ST_CLIP: begin
            priority if (sts.a_in && sts.b_in) begin
               state_in = pecs_pkg::ST_PUSH_B;
            end else if (sts.a_in != sts.b_in) begin
               point_in = pecs_pkg::PT_A;
               state_in = pecs_pkg::ST_EF_M1;
            end else begin
               state_in = pecs_pkg::ST_EDGE_DONE;
            end
         end
         pecs_pkg::ST_INT_CHECK: begin
            if (sts.den_zero) begin
               state_in = pecs_pkg::ST_PUSH_A;
            end else begin
               coord_in = pecs_pkg::COORD_X;
               state_in = pecs_pkg::ST_NUM_M1;
            end
         end
         pecs_pkg::ST_NUM_M1:  state_in = pecs_pkg::ST_NUM_M1W;
         pecs_pkg::ST_NUM_M1W: if (sts.mul_done) state_in = pecs_pkg::ST_NUM_M2;
         pecs_pkg::ST_NUM_M2:  state_in = pecs_pkg::ST_NUM_M2W;
         pecs_pkg::ST_NUM_M2W: if (sts.mul_done) state_in = pecs_pkg::ST_DIV;
         pecs_pkg::ST_DIV:     state_in = pecs_pkg::ST_DIVW;
         pecs_pkg::ST_DIVW: begin
            if (sts.div_done) begin
               if (coord_ff == pecs_pkg::COORD_X) begin
                  coord_in = pecs_pkg::COORD_Y;
                  state_in = pecs_pkg::ST_NUM_M1;
               end else begin
                  state_in = pecs_pkg::ST_PUSH_Q;
               end
            end
         end
         pecs_pkg::ST_PUSH_A, pecs_pkg::ST_PUSH_Q: begin
            if (sts.out_free) begin
               state_in = sts.b_in ? pecs_pkg::ST_PUSH_B : pecs_pkg::ST_EDGE_DONE;
            end
         end
         pecs_pkg::ST_PUSH_B: if (sts.out_free) state_in = pecs_pkg::ST_EDGE_DONE;
         pecs_pkg::ST_EDGE_DONE: begin
            state_in = (edge_ff == pecs_pkg::EDGE_PREV_CUR) ?
                       pecs_pkg::ST_CHECK_LAST : pecs_pkg::ST_FLUSH;
         end
         pecs_pkg::ST_CHECK_LAST: begin
            if (sts.last) begin
               point_in = pecs_pkg::PT_FIRST;
               state_in = pecs_pkg::ST_EF_M1;
            end else begin
               state_in = pecs_pkg::ST_FLUSH;
            end
         end
         pecs_pkg::ST_FLUSH: if (sts.out_free) state_in = pecs_pkg::ST_IDLE;
         default: state_in = pecs_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd           = '0;
      cmd.point     = point_ff;
      cmd.edge_sel  = edge_ff;
      cmd.coord     = coord_ff;
      cmd.mul_op    = pecs_pkg::MUL_EF1;
      cmd.push_src  = pecs_pkg::SRC_B;
      req_ready     = 1'b0;
      unique case (state_ff)
         pecs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pecs_pkg::ST_EF_M1: cmd.mul_start = 1'b1;
         pecs_pkg::ST_EF_M2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = pecs_pkg::MUL_EF2;
         end
         pecs_pkg::ST_NUM_M1: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = pecs_pkg::MUL_N1;
         end
         pecs_pkg::ST_NUM_M2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = pecs_pkg::MUL_N2;
         end
         pecs_pkg::ST_EF_STORE: cmd.store_e   = 1'b1;
         pecs_pkg::ST_SET_EDGE: cmd.set_edge  = 1'b1;
         pecs_pkg::ST_DIV:      cmd.div_start = 1'b1;
         pecs_pkg::ST_PUSH_A: begin
            cmd.push     = sts.out_free;
            cmd.push_src = pecs_pkg::SRC_A;
         end
         pecs_pkg::ST_PUSH_Q: begin
            cmd.push     = sts.out_free;
            cmd.push_src = pecs_pkg::SRC_Q;
         end
         pecs_pkg::ST_PUSH_B: cmd.push = sts.out_free;
         pecs_pkg::ST_FLUSH: begin
            cmd.flush  = sts.out_free;
            cmd.commit = sts.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pecs_pkg::ST_IDLE;
         point_ff <= pecs_pkg::PT_CUR;
         edge_ff  <= pecs_pkg::EDGE_PREV_CUR;
         coord_ff <= pecs_pkg::COORD_X;
      end else begin
         state_ff <= state_in;
         point_ff <= point_in;
         edge_ff  <= edge_in;
         coord_ff <= coord_in;
      end
   end

   // Checks
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul_start, cmd.div_start, cmd.push, cmd.flush}))
      else $error("more than one datapath action in a cycle");

   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == pecs_pkg::ST_IDLE))
      else $error("vertex commit did not return to idle");

   a_clip_after_edge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pecs_pkg::ST_CLIP) |-> ($past(state_ff) == pecs_pkg::ST_SET_EDGE))
      else $error("edge decision without a loaded edge");

endmodule

// ===== rtl/core/polygon_edge_clip_stage.sv =====
// ----------------------------------------------------------------------------
// polygon_edge_clip_stage
// One polygon clipping stage against a configured line: vertices in, clipped
// vertices out, with a polygon end mark on the last result.
// ----------------------------------------------------------------------------
//
//   channel | direction | fields
//   req_    | in        | tdata: vertex_x, vertex_y; tlast: last_vertex
//   rsp_    | out       | tdata: out_x, out_y; tuser: vertex_valid; tlast: polygon_end
//   csr_    | in        | APB: edge_start_x, edge_start_y, edge_end_x, edge_end_y
//
// One vertex at a time. Multiplies run on the serial multiplier and divisions
// on the restoring divider. A vertex costs two multiplies for its edge
// function, a crossing edge adds eight multiplies and two divisions, and a
// last vertex adds two multiplies for the first vertex.
// Reset is synchronous and clears the configuration registers and the polygon state.
// A stalled result holds in the output register while the next vertex is taken.
//
module polygon_edge_clip_stage #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // vertex_x [COORD_BITS-1:0], vertex_y above it, zero padding to bytes
   input  logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x [COORD_BITS-1:0], out_y above it, zero padding to bytes
   output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // vertex_valid
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   localparam int C  = COORD_BITS;
   localparam int TW = ((2 * COORD_BITS + 7) / 8) * 8;

   logic signed [C-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic signed [C-1:0] rsp_x, rsp_y;
   logic                rsp_vv, rsp_pe, csr_wr;
   pecs_pkg::cmd_type    cmd;
   pecs_pkg::status_type sts;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= '0;
         end_y_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            pecs_pkg::REG_START_X: start_x_ff <= csr_pwdata[C-1:0];
            pecs_pkg::REG_START_Y: start_y_ff <= csr_pwdata[C-1:0];
            pecs_pkg::REG_END_X:   end_x_ff   <= csr_pwdata[C-1:0];
            pecs_pkg::REG_END_Y:   end_y_ff   <= csr_pwdata[C-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         pecs_pkg::REG_START_X: csr_prdata = 32'(start_x_ff);
         pecs_pkg::REG_START_Y: csr_prdata = 32'(start_y_ff);
         pecs_pkg::REG_END_X:   csr_prdata = 32'(end_x_ff);
         pecs_pkg::REG_END_Y:   csr_prdata = 32'(end_y_ff);
      endcase
   end

   pecs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pecs_dpath #(.C(C)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_x      (req_tdata[C-1:0]),
      .in_y      (req_tdata[2*C-1:C]),
      .in_last   (req_tlast),
      .start_x   (start_x_ff),
      .start_y   (start_y_ff),
      .end_x     (end_x_ff),
      .end_y     (end_y_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_vv    (rsp_vv),
      .rsp_pe    (rsp_pe)
   );

   // Pack the result transfer
   assign rsp_tdata = TW'({rsp_y, rsp_x});
   assign rsp_tuser = rsp_vv;
   assign rsp_tlast = rsp_pe;

endmodule
